// ----- src/ffa_pkg.sv -----
package ffa_pkg;

	localparam int OFF_W = 17;
	localparam int REQ_W = 32;
	localparam int ST_W  = 2;
	localparam int EW    = 2 * OFF_W + 1;

	typedef struct packed {
		logic             free;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] off;
	} seg_t;

	typedef enum logic [ST_W-1:0] {
		ST_ALLOC   = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_FREED   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_CHK,
		S_MV_RD,
		S_MV_WR,
		S_SPLIT_A,
		S_SPLIT_B,
		S_MARK,
		S_FREE_WR,
		S_MG_RD0,
		S_MG_CUR,
		S_MG_RD,
		S_MG_CHK,
		S_MG_END
	} state_t;

	localparam logic OP_ALLOC = 1'b0;

endpackage

// ----- src/ffa_ram.sv -----
module ffa_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator with merging of free segments.
// Input channel s_*: s_tuser[0] is the operation (0 allocate, 1 free);
// s_tdata holds the requested size and the payload offset to release.
// Output channel m_*: one item per request; m_tdata carries the granted payload
// offset (0 when none), m_tuser the status (allocated, no fit, freed, ignored).
// The segment table sits in one RAM with a registered read port; a sequencer
// walks it entry by entry through a compare/add datapath.
// Allocate scans entries in order for the first free one that fits and marks it used;
// when it splits, it first moves the later entries up by one and writes the free
// remainder. With no fit it scans all live segments. Free searches for the entry with
// the given payload offset, marks it free, then walks all live segments to merge.
// A rejected request or a null release answers in the next cycle.
// After reset the S_INIT state writes the initial whole-heap segment; s_tready stays
// low until then. s_tready is high only while the sequencer is idle and the
// output register is empty or being taken, so a stalled receiver holds the
// result in place and stalls new requests.
module first_fit_heap_allocator_top
	import ffa_pkg::*;
#(
	parameter int HEAP_BYTES   = 131072,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_SEGMENTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // req_size[31:0], release_offset[48:32], zero fill
	input  logic [0:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // payload_offset[16:0], zero fill
	output logic [1:0]  m_tuser   // status
);

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = AW + 1;
	localparam logic [OFF_W:0]   HDR   = (OFF_W + 1)'(HEADER_BYTES);
	localparam logic [REQ_W-1:0] MAXSZ = REQ_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0]    MAXC  = CW'(MAX_SEGMENTS);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, idx_q, j_q, w_q;
	logic          op_q;
	logic [OFF_W-1:0] size_q, rel_q;
	seg_t cur_q;
	logic m_valid_q;
	logic [OFF_W-1:0] out_off_q;
	status_t out_st_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	seg_t wdata, rd;
	logic [EW-1:0] rdata;

	logic done;
	logic [OFF_W-1:0] res_off;
	status_t res_st;

	logic [REQ_W-1:0] req_size;
	logic [OFF_W-1:0] rel_in, rounded;
	logic [OFF_W:0] sum_a, sum_b;
	logic fits, split;

	assign req_size = s_tdata[31:0];
	assign rel_in   = s_tdata[48:32];
	assign rounded  = (req_size[OFF_W-1:0] + OFF_W'(15)) & ~OFF_W'(15);
	assign rd       = seg_t'(rdata);
	assign sum_a    = {1'b0, rd.off} + HDR;
	assign sum_b    = {1'b0, size_q} + HDR + (OFF_W + 1)'(16);
	assign fits     = rd.free && (rd.size >= size_q);
	assign split    = ({1'b0, rd.size} >= sum_b) && (cnt_q < MAXC);
	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);

	ffa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = cur_q;
		raddr   = idx_q[AW-1:0];
		done    = 1'b0;
		res_off = '0;
		res_st  = ST_NOFIT;
		unique case (state_q)
			S_INIT: begin
				we      = 1'b1;
				wdata   = '{free: 1'b1, size: OFF_W'(HEAP_BYTES - HEADER_BYTES), off: '0};
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					if (s_tuser[0] == OP_ALLOC) begin
						if (req_size == '0 || req_size > MAXSZ) begin
							done = 1'b1;
						end else begin
							state_d = S_RD;
						end
					end else if (rel_in == '0) begin
						done   = 1'b1;
						res_st = ST_IGNORED;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (idx_q == cnt_q) begin
					done    = 1'b1;
					res_st  = (op_q == OP_ALLOC) ? ST_NOFIT : ST_IGNORED;
					state_d = S_IDLE;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (op_q == OP_ALLOC) begin
					if (fits) begin
						if (split) begin
							state_d = (cnt_q - 1'b1 >= idx_q + 1'b1) ? S_MV_RD : S_SPLIT_A;
						end else begin
							state_d = S_MARK;
						end
					end else begin
						state_d = S_RD;
					end
				end else begin
					state_d = (sum_a == {1'b0, rel_q}) ? S_FREE_WR : S_RD;
				end
			end
			S_MV_RD: begin
				raddr   = j_q[AW-1:0];
				state_d = S_MV_WR;
			end
			S_MV_WR: begin
				we      = 1'b1;
				waddr   = AW'(j_q + 1'b1);
				wdata   = rd;
				state_d = (j_q == idx_q + 1'b1) ? S_SPLIT_A : S_MV_RD;
			end
			S_SPLIT_A: begin
				we          = 1'b1;
				waddr       = AW'(idx_q + 1'b1);
				wdata.free  = 1'b1;
				wdata.off   = cur_q.off + OFF_W'(HEADER_BYTES) + size_q;
				wdata.size  = cur_q.size - size_q - OFF_W'(HEADER_BYTES);
				state_d     = S_SPLIT_B;
			end
			S_SPLIT_B, S_MARK: begin
				we         = 1'b1;
				waddr      = idx_q[AW-1:0];
				wdata.free = 1'b0;
				if (state_q == S_SPLIT_B) begin
					wdata.size = size_q;
				end
				done    = 1'b1;
				res_st  = ST_ALLOC;
				res_off = cur_q.off + OFF_W'(HEADER_BYTES);
				state_d = S_IDLE;
			end
			S_FREE_WR: begin
				we         = 1'b1;
				waddr      = idx_q[AW-1:0];
				wdata.free = 1'b1;
				state_d    = S_MG_RD0;
			end
			S_MG_RD0: begin
				raddr   = '0;
				state_d = S_MG_CUR;
			end
			S_MG_CUR: begin
				state_d = S_MG_RD;
			end
			S_MG_RD: begin
				state_d = (idx_q == cnt_q) ? S_MG_END : S_MG_CHK;
			end
			S_MG_CHK: begin
				if (!(cur_q.free && rd.free)) begin
					we    = 1'b1;
					waddr = w_q[AW-1:0];
				end
				state_d = S_MG_RD;
			end
			S_MG_END: begin
				we      = 1'b1;
				waddr   = w_q[AW-1:0];
				done    = 1'b1;
				res_st  = ST_FREED;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CW'(1);
			m_valid_q <= 1'b0;
		end else begin
			if (done) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == S_INIT) begin
				cnt_q <= CW'(1);
			end else if (state_q == S_SPLIT_B) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == S_MG_END) begin
				cnt_q <= w_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_off_q <= res_off;
			out_st_q  <= res_st;
		end
		unique case (state_q)
			S_IDLE: begin
				op_q   <= s_tuser[0];
				size_q <= rounded;
				rel_q  <= rel_in;
				idx_q  <= '0;
			end
			S_CHK: begin
				cur_q <= rd;
				j_q   <= cnt_q - 1'b1;
				if (!(op_q == OP_ALLOC ? fits : (sum_a == {1'b0, rel_q}))) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_MV_WR: begin
				j_q <= j_q - 1'b1;
			end
			S_MG_CUR: begin
				cur_q <= rd;
				w_q   <= '0;
				idx_q <= CW'(1);
			end
			S_MG_CHK: begin
				idx_q <= idx_q + 1'b1;
				if (cur_q.free && rd.free) begin
					cur_q.size <= cur_q.size + OFF_W'(HEADER_BYTES) + rd.size;
				end else begin
					cur_q <= rd;
					w_q   <= w_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(24 - OFF_W){1'b0}}, out_off_q};
	assign m_tuser  = out_st_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= MAXC))
		else $error("segment count out of range");

	a_alloc_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_ALLOC) |-> (m_tdata[OFF_W-1:0] != '0))
		else $error("allocation granted at offset zero");

	a_nonalloc_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_ALLOC) |-> (m_tdata[OFF_W-1:0] == '0))
		else $error("offset returned without allocation");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("ready while busy");

	a_split_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT_B) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("split did not add a segment");

endmodule

// ----- test/tb_first_fit_heap_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;
	import ffa_pkg::*;

	localparam int HEAP_BYTES   = 131072;
	localparam int HEADER_BYTES = 32;
	localparam int MAX_SEGMENTS = 4096;
	localparam int IDLE_LIMIT   = 400000;
	localparam int N_RANDOM     = 1280;
	localparam logic OP_FREE    = 1'b1;

	typedef struct {
		logic             op;
		logic [31:0]      req_size;
		logic [OFF_W-1:0] rel;
		bit               typed;
		logic [OFF_W-1:0] exp_off;
		status_t          exp_st;
	} request_t;

	typedef struct {
		logic [OFF_W-1:0] off;
		status_t          st;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [OFF_W-1:0] heap_seg_off [MAX_SEGMENTS];
	logic [OFF_W-1:0] heap_seg_size[MAX_SEGMENTS];
	bit               heap_seg_free[MAX_SEGMENTS];
	int               heap_seg_n;

	grant_t           pending_grants[$];
	logic [OFF_W-1:0] live_offsets[$];
	int               error_count = 0;
	int               idle_cycles = 0;
	int               send_idle_pct;
	int               recv_stall_pct;

	first_fit_heap_allocator_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void merge_free_segments();
		int w;
		w = 0;
		for (int r = 1; r < heap_seg_n; r++) begin
			if (heap_seg_free[w] && heap_seg_free[r]) begin
				heap_seg_size[w] = OFF_W'(heap_seg_size[w] + HEADER_BYTES + heap_seg_size[r]);
			end else begin
				w++;
				heap_seg_off[w]  = heap_seg_off[r];
				heap_seg_size[w] = heap_seg_size[r];
				heap_seg_free[w] = heap_seg_free[r];
			end
		end
		heap_seg_n = w + 1;
	endfunction

	function automatic grant_t heap_update(input logic op, input logic [31:0] req_size,
			input logic [OFF_W-1:0] rel);
		grant_t g;
		longint rounded;
		g.off = '0;
		g.st  = ST_NOFIT;
		if (op == OP_ALLOC) begin
			if (req_size == 0 || req_size > HEAP_BYTES - HEADER_BYTES)
				return g;
			rounded = (longint'(req_size) + 15) & ~longint'(15);
			for (int i = 0; i < heap_seg_n; i++) begin
				if (!heap_seg_free[i] || longint'(heap_seg_size[i]) < rounded)
					continue;
				if (longint'(heap_seg_size[i]) >= rounded + HEADER_BYTES + 16 &&
						heap_seg_n < MAX_SEGMENTS) begin
					for (int j = heap_seg_n - 1; j > i; j--) begin
						heap_seg_off[j+1]  = heap_seg_off[j];
						heap_seg_size[j+1] = heap_seg_size[j];
						heap_seg_free[j+1] = heap_seg_free[j];
					end
					heap_seg_off[i+1]  = OFF_W'(longint'(heap_seg_off[i]) + HEADER_BYTES +
						rounded);
					heap_seg_size[i+1] = OFF_W'(longint'(heap_seg_size[i]) - rounded -
						HEADER_BYTES);
					heap_seg_free[i+1] = 1'b1;
					heap_seg_size[i]   = OFF_W'(rounded);
					heap_seg_n++;
				end
				heap_seg_free[i] = 1'b0;
				g.off = OFF_W'(heap_seg_off[i] + HEADER_BYTES);
				g.st  = ST_ALLOC;
				return g;
			end
			return g;
		end
		g.st = ST_IGNORED;
		if (rel == 0)
			return g;
		for (int i = 0; i < heap_seg_n; i++) begin
			if (int'(heap_seg_off[i]) + HEADER_BYTES == int'(rel)) begin
				heap_seg_free[i] = 1'b1;
				merge_free_segments();
				g.st = ST_FREED;
				return g;
			end
		end
		return g;
	endfunction

	task automatic send_request(input request_t rq);
		grant_t g;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, rq.rel, rq.req_size};
		s_tuser  <= rq.op;
		do
			@(posedge clk);
		while (!s_tready);
		g = heap_update(rq.op, rq.req_size, rq.rel);
		if (g.st == ST_ALLOC)
			live_offsets.push_back(g.off);
		if (rq.typed) begin
			g.off = rq.exp_off;
			g.st  = rq.exp_st;
		end
		pending_grants.push_back(g);
		@(negedge clk);
	endtask

	function automatic request_t make_row(logic op, logic [31:0] sz, logic [OFF_W-1:0] rel,
			bit typed, logic [OFF_W-1:0] off, status_t st);
		request_t rq;
		rq.op = op;
		rq.req_size = sz;
		rq.rel = rel;
		rq.typed = typed;
		rq.exp_off = off;
		rq.exp_st = st;
		return rq;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int pick;
		int sel;
		rq = make_row(OP_ALLOC, 32'd0, '0, 1'b0, '0, ST_ALLOC);
		pick = $urandom_range(99);
		if (pick < 52) begin
			sel = $urandom_range(99);
			if (sel < 70)
				rq.req_size = $urandom_range(512, 1);
			else if (sel < 95)
				rq.req_size = $urandom_range(4096, 1);
			else
				rq.req_size = $urandom_range(HEAP_BYTES - HEADER_BYTES, 1);
		end else if (pick < 84 && live_offsets.size() > 0) begin
			sel = $urandom_range(live_offsets.size() - 1);
			rq.op = OP_FREE;
			rq.rel = live_offsets[sel];
			live_offsets.delete(sel);
			rq.req_size = $urandom;
		end else begin
			sel = $urandom_range(4);
			rq.req_size = $urandom;
			rq.rel = OFF_W'($urandom);
			if (sel == 0) begin
				rq.req_size = (sel == 0 && $urandom_range(1)) ? 32'd0 : rq.req_size;
			end else begin
				rq.op = OP_FREE;
				if (sel == 1)
					rq.rel = '0;
				else if (sel == 2 && heap_seg_n > 0)
					rq.rel = OFF_W'(heap_seg_off[$urandom_range(heap_seg_n - 1)] +
						HEADER_BYTES);
			end
		end
		return rq;
	endfunction

	always @(posedge clk) begin
		grant_t g;
		if (m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				$error("result with nothing expected: payload_offset %0d status %0d",
					m_tdata[OFF_W-1:0], m_tuser);
				error_count++;
			end else begin
				g = pending_grants.pop_front();
				if (m_tdata[OFF_W-1:0] !== g.off) begin
					$error("payload_offset expected %0d actual %0d", g.off,
						m_tdata[OFF_W-1:0]);
					error_count++;
				end
				if (m_tuser !== g.st) begin
					$error("status expected %0d actual %0d", g.st, m_tuser);
					error_count++;
				end
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		request_t directed[$];
		int phase_pct[4][2];
		int wait_cycles;
		phase_pct = '{'{0, 0}, '{83, 0}, '{0, 83}, '{23, 23}};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		heap_seg_off[0]  = '0;
		heap_seg_size[0] = OFF_W'(HEAP_BYTES - HEADER_BYTES);
		heap_seg_free[0] = 1'b1;
		heap_seg_n       = 1;

		directed.push_back(make_row(OP_ALLOC, 32'd1, '0, 1, 17'd32, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd0, '0, 1, '0, ST_NOFIT));
		directed.push_back(make_row(OP_ALLOC, 32'd131041, '0, 1, '0, ST_NOFIT));
		directed.push_back(make_row(OP_ALLOC, 32'hFFFF_FFFF, 17'h1FFFF, 1, '0, ST_NOFIT));
		directed.push_back(make_row(OP_FREE, 32'hFFFF_FFFF, '0, 1, '0, ST_IGNORED));
		directed.push_back(make_row(OP_FREE, '0, 17'h1FFFF, 1, '0, ST_IGNORED));
		directed.push_back(make_row(OP_FREE, '0, 17'd5, 1, '0, ST_IGNORED));
		directed.push_back(make_row(OP_ALLOC, 32'd100, '0, 0, '0, ST_ALLOC));
		directed.push_back(make_row(OP_FREE, '0, 17'd32, 1, '0, ST_FREED));
		directed.push_back(make_row(OP_FREE, '0, 17'd32, 1, '0, ST_FREED));
		directed.push_back(make_row(OP_FREE, '0, 17'd80, 0, '0, ST_FREED));
		directed.push_back(make_row(OP_ALLOC, 32'd131040, '0, 1, 17'd32, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd16, '0, 1, '0, ST_NOFIT));
		directed.push_back(make_row(OP_FREE, '0, 17'd32, 1, '0, ST_FREED));
		directed.push_back(make_row(OP_ALLOC, 32'd131024, '0, 1, 17'd32, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd1, '0, 1, '0, ST_NOFIT));
		directed.push_back(make_row(OP_FREE, '0, 17'd32, 1, '0, ST_FREED));
		directed.push_back(make_row(OP_ALLOC, 32'd15, '0, 0, '0, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd16, '0, 0, '0, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd17, '0, 0, '0, ST_ALLOC));
		directed.push_back(make_row(OP_FREE, '0, 17'd80, 0, '0, ST_FREED));
		directed.push_back(make_row(OP_ALLOC, 32'd131040, '0, 0, '0, ST_ALLOC));
		directed.push_back(make_row(OP_ALLOC, 32'd8, '0, 0, '0, ST_ALLOC));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_request(directed[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			send_idle_pct  = phase_pct[(n * 4) / N_RANDOM][0];
			recv_stall_pct = phase_pct[(n * 4) / N_RANDOM][1];
			send_request(random_request());
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;

		while (pending_grants.size() != 0)
			@(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 50) begin
			@(posedge clk);
			wait_cycles++;
		end

		if (error_count == 0 && pending_grants.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- first_fit_heap_allocator_top.f -----
src/ffa_pkg.sv
src/ffa_ram.sv
src/first_fit_heap_allocator_top.sv
test/tb_first_fit_heap_allocator_top.sv
